[rtl/rprc_pkg.sv]
`timescale 1ns / 1ps
// Package for the RTT-penalized Reno window engine: field widths, reset values,
// codes and the sequencer state type. No dependencies.
package rprc_pkg;

  localparam int CWND_BITS_DEF  = 20;
  localparam int KIND_BITS      = 2;
  localparam int ACKED_BITS     = 16;
  localparam int SRTT_BITS      = 28;
  localparam int SRTT_SHIFT     = 3;
  localparam int BASE_RTT_BITS  = 24;
  localparam int PENALTY_BITS   = 8;
  localparam int CLAMP_BITS     = 20;
  localparam int CNT_BITS       = 32;
  localparam int DIV_BITS       = CNT_BITS + 1;
  localparam int ALU_MIN_BITS   = CNT_BITS + 2;
  localparam int STEP_BITS      = $clog2(DIV_BITS);
  localparam int CFG_IDX_BITS   = 2;
  localparam int CFG_DATA_BITS  = 24;
  localparam int MIN_SSTHRESH   = 2;

  localparam logic [BASE_RTT_BITS-1:0] RESET_BASE_RTT = BASE_RTT_BITS'(20000);
  localparam logic [PENALTY_BITS-1:0]  RESET_PENALTY  = PENALTY_BITS'(10);
  localparam logic [CLAMP_BITS-1:0]    RESET_CLAMP    = '1;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_ACK  = 2'd0,
    KIND_LOSS = 2'd1,
    KIND_RTO  = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    IDX_BASE_RTT = 2'd0,
    IDX_PENALTY  = 2'd1,
    IDX_CLAMP    = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SS_CHK,
    ST_SS_SUM,
    ST_SS_MIN,
    ST_SS_LEFT,
    ST_SS_CLAMP,
    ST_PEN,
    ST_MUL,
    ST_WCHK,
    ST_INC1,
    ST_ADDACK,
    ST_DIVCHK,
    ST_DIV,
    ST_ADDQ,
    ST_CLAMP,
    ST_REDUCE,
    ST_DONE
  } state_t;

endpackage

[rtl/rprc_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces: request input, result output, config write.
// Depends on rprc_pkg.
interface rprc_in_if;
  import rprc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [KIND_BITS-1:0]  kind;
  logic [ACKED_BITS-1:0] acked;
  logic [SRTT_BITS-1:0]  srtt_scaled;
  logic                  window_limited;
  modport source (output valid, kind, acked, srtt_scaled, window_limited, input ready);
  modport sink   (input valid, kind, acked, srtt_scaled, window_limited, output ready);
endinterface

interface rprc_out_if #(
  parameter int CWND_BITS = rprc_pkg::CWND_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [CWND_BITS-1:0] cwnd_out;
  logic [CWND_BITS-1:0] ssthresh_out;
  modport source (output valid, cwnd_out, ssthresh_out, input ready);
  modport sink   (input valid, cwnd_out, ssthresh_out, output ready);
endinterface

interface rprc_cfg_if;
  import rprc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/rprc_alu.sv]
`timescale 1ns / 1ps
// Shared add/subtract unit of the window sequencer; subtract also flags a < b.
// Depends on rprc_pkg.
module rprc_alu #(
  parameter int DW = rprc_pkg::ALU_MIN_BITS
) (
  input  rprc_pkg::alu_op_t op,
  input  logic [DW-1:0]     a,
  input  logic [DW-1:0]     b,
  output logic [DW-1:0]     res,
  output logic              lt
);
  import rprc_pkg::*;

  logic [DW:0] ext;

  always_comb begin
    unique case (op)
      ALU_ADD: ext = {1'b0, a} + {1'b0, b};
      ALU_SUB: ext = {1'b0, a} - {1'b0, b};
      default: ext = '0;
    endcase
  end

  assign res = ext[DW-1:0];
  assign lt  = (op == ALU_SUB) && ext[DW];

endmodule

[rtl/rprc_cfg_regs.sv]
`timescale 1ns / 1ps
// Configuration register file: base RTT, penalty factor, window clamp.
// Depends on rprc_pkg and rprc_cfg_if.
module rprc_cfg_regs (
  input  logic                                  clk,
  input  logic                                  rst_n,
  rprc_cfg_if.sink                              cfg,
  output logic [rprc_pkg::BASE_RTT_BITS-1:0]    base_rtt,
  output logic [rprc_pkg::PENALTY_BITS-1:0]     penalty,
  output logic [rprc_pkg::CLAMP_BITS-1:0]       clamp
);
  import rprc_pkg::*;

  logic [BASE_RTT_BITS-1:0] base_rtt_r, base_rtt_nxt;
  logic [PENALTY_BITS-1:0]  penalty_r,  penalty_nxt;
  logic [CLAMP_BITS-1:0]    clamp_r,    clamp_nxt;

  assign cfg.ready = 1'b1;

  always_comb begin
    base_rtt_nxt = base_rtt_r;
    penalty_nxt  = penalty_r;
    clamp_nxt    = clamp_r;
    if (cfg.valid) begin
      unique case (cfg_idx_t'(cfg.index))
        IDX_BASE_RTT: base_rtt_nxt = cfg.data[BASE_RTT_BITS-1:0];
        IDX_PENALTY:  penalty_nxt  = cfg.data[PENALTY_BITS-1:0];
        IDX_CLAMP:    clamp_nxt    = cfg.data[CLAMP_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_rtt_r <= RESET_BASE_RTT;
      penalty_r  <= RESET_PENALTY;
      clamp_r    <= RESET_CLAMP;
    end else begin
      base_rtt_r <= base_rtt_nxt;
      penalty_r  <= penalty_nxt;
      clamp_r    <= clamp_nxt;
    end
  end

  assign base_rtt = base_rtt_r;
  assign penalty  = penalty_r;
  assign clamp    = clamp_r;

endmodule

[rtl/rtt_penalized_reno_cwnd.sv]
`timescale 1ns / 1ps
// Reno congestion window engine for one flow with an RTT penalty on fast flows.
// Depends on rprc_pkg, rprc_if, rprc_alu and rprc_cfg_regs.
//
// One request at a time: in_ch.ready is high only while the sequencer is idle,
// and every step of the update runs through a single add/subtract unit. A
// result sits in an output register, so a new request is taken while the last
// result waits. An ack that is not window-limited or an unused kind goes
// straight to the result, loss and timeout pass through the reduce step, and
// an ack that stays in slow start runs the slow start steps. Congestion
// avoidance comes after the slow start steps when leftover slow start acks
// spill into it, bumps the window when the count already sits at the target,
// and runs the bit-serial penalty multiply (fast flows only) and the restoring
// divide (only when the increase count reaches the target) through the shared
// unit.
// Loss and timeout halve the window (floor 2) into ssthresh; timeout drops
// the window to 1. Ack growth is clamped to the configured window clamp.
module rtt_penalized_reno_cwnd #(
  parameter int CWND_BITS = rprc_pkg::CWND_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rprc_in_if.sink     in_ch,
  rprc_out_if.source  out_ch,
  rprc_cfg_if.sink    cfg_ch
);
  import rprc_pkg::*;

  localparam int DW = (CWND_BITS + PENALTY_BITS > ALU_MIN_BITS) ?
                      CWND_BITS + PENALTY_BITS : ALU_MIN_BITS;
  localparam int SRTT_KEEP = SRTT_BITS - SRTT_SHIFT;

  // saturate the increase counter at all ones
  function automatic logic [CNT_BITS-1:0] sat_cnt(input logic [DIV_BITS-1:0] v);
    logic [CNT_BITS-1:0] r;
    r = v[CNT_BITS] ? '1 : v[CNT_BITS-1:0];
    return r;
  endfunction

  logic [BASE_RTT_BITS-1:0] base_rtt;
  logic [PENALTY_BITS-1:0]  penalty;
  logic [CLAMP_BITS-1:0]    clamp;
  logic [PENALTY_BITS-1:0]  pf_eff;

  alu_op_t       alu_op;
  logic [DW-1:0] alu_a, alu_b, alu_res;
  logic          alu_lt;

  state_t                state_r, state_nxt;
  logic [CWND_BITS-1:0]  cwnd_r, cwnd_nxt;
  logic [CWND_BITS-1:0]  ssth_r, ssth_nxt;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [CWND_BITS-1:0]  out_cwnd_r, out_cwnd_nxt;
  logic [CWND_BITS-1:0]  out_ssth_r, out_ssth_nxt;
  logic [KIND_BITS-1:0]  kind_r, kind_nxt;
  logic [ACKED_BITS-1:0] acked_r, acked_nxt;
  logic [SRTT_KEEP-1:0]  srtt_r, srtt_nxt;
  logic [DW-1:0]         acc_r, acc_nxt;
  logic [DW-1:0]         opb_r, opb_nxt;
  logic [DW-1:0]         cw_r, cw_nxt;
  logic [DW-1:0]         rem_r, rem_nxt;
  logic [DIV_BITS-1:0]   dq_r, dq_nxt;
  logic [STEP_BITS-1:0]  step_r, step_nxt;

  logic [DW-1:0]         w_eff;
  logic [DW-1:0]         part;
  logic [CWND_BITS-1:0]  half;
  logic [CWND_BITS-1:0]  red_ssth;

  rprc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_ch),
    .base_rtt (base_rtt),
    .penalty  (penalty),
    .clamp    (clamp)
  );

  rprc_alu #(.DW(DW)) u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res),
    .lt  (alu_lt)
  );

  assign pf_eff   = (penalty == '0) ? PENALTY_BITS'(1) : penalty;
  assign w_eff    = (opb_r == '0) ? DW'(1) : opb_r;
  assign part     = {rem_r[DW-2:0], dq_r[DIV_BITS-1]};
  assign half     = cwnd_r >> 1;
  assign red_ssth = alu_lt ? CWND_BITS'(MIN_SSTHRESH) : half;

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.cwnd_out     = out_cwnd_r;
  assign out_ch.ssthresh_out = out_ssth_r;

  always_comb begin
    state_nxt     = state_r;
    cwnd_nxt      = cwnd_r;
    ssth_nxt      = ssth_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_cwnd_nxt  = out_cwnd_r;
    out_ssth_nxt  = out_ssth_r;
    kind_nxt      = kind_r;
    acked_nxt     = acked_r;
    srtt_nxt      = srtt_r;
    acc_nxt       = acc_r;
    opb_nxt       = opb_r;
    cw_nxt        = cw_r;
    rem_nxt       = rem_r;
    dq_nxt        = dq_r;
    step_nxt      = step_r;
    alu_op        = ALU_SUB;
    alu_a         = '0;
    alu_b         = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          kind_nxt  = in_ch.kind;
          acked_nxt = in_ch.acked;
          srtt_nxt  = in_ch.srtt_scaled[SRTT_BITS-1:SRTT_SHIFT];
          case (in_ch.kind) inside
            KIND_ACK:           state_nxt = in_ch.window_limited ? ST_SS_CHK : ST_DONE;
            KIND_LOSS, KIND_RTO: state_nxt = ST_REDUCE;
            default:            state_nxt = ST_DONE;
          endcase
        end
      end
      // slow start when cwnd <= ssthresh
      ST_SS_CHK: begin
        alu_a     = DW'(ssth_r);
        alu_b     = DW'(cwnd_r);
        state_nxt = alu_lt ? ST_PEN : ST_SS_SUM;
      end
      ST_SS_SUM: begin
        alu_op    = ALU_ADD;
        alu_a     = DW'(cwnd_r);
        alu_b     = DW'(acked_r);
        acc_nxt   = alu_res;
        state_nxt = ST_SS_MIN;
      end
      // grown = min(cwnd + acked, ssthresh), hold the sum in acc
      ST_SS_MIN: begin
        alu_a     = acc_r;
        alu_b     = DW'(ssth_r);
        opb_nxt   = alu_lt ? acc_r : DW'(ssth_r);
        state_nxt = ST_SS_LEFT;
      end
      // leftover acked = sum - grown
      ST_SS_LEFT: begin
        alu_a     = acc_r;
        alu_b     = opb_r;
        acked_nxt = alu_res[ACKED_BITS-1:0];
        state_nxt = ST_SS_CLAMP;
      end
      ST_SS_CLAMP: begin
        alu_a     = opb_r;
        alu_b     = DW'(clamp);
        cwnd_nxt  = alu_lt ? opb_r[CWND_BITS-1:0] : CWND_BITS'(clamp);
        state_nxt = (acked_r != '0) ? ST_PEN : ST_DONE;
      end
      // penalize when srtt/8 < base RTT
      ST_PEN: begin
        alu_a  = DW'(srtt_r);
        alu_b  = DW'(base_rtt);
        cw_nxt = DW'(cwnd_r);
        if (alu_lt) begin
          acc_nxt   = '0;
          step_nxt  = STEP_BITS'(PENALTY_BITS - 1);
          state_nxt = ST_MUL;
        end else begin
          opb_nxt   = DW'(cwnd_r);
          state_nxt = ST_WCHK;
        end
      end
      // target = cwnd * factor, shift-add from the top factor bit
      ST_MUL: begin
        alu_op  = ALU_ADD;
        alu_a   = acc_r << 1;
        alu_b   = pf_eff[step_r[$clog2(PENALTY_BITS)-1:0]] ? cw_r : '0;
        acc_nxt = alu_res;
        if (step_r == '0) begin
          opb_nxt   = alu_res;
          state_nxt = ST_WCHK;
        end else begin
          step_nxt = step_r - STEP_BITS'(1);
        end
      end
      // a count already at target bumps the window and restarts
      ST_WCHK: begin
        alu_a   = DW'(cnt_r);
        alu_b   = w_eff;
        opb_nxt = w_eff;
        if (!alu_lt) begin
          cnt_nxt   = '0;
          state_nxt = ST_INC1;
        end else begin
          state_nxt = ST_ADDACK;
        end
      end
      ST_INC1: begin
        alu_op    = ALU_ADD;
        alu_a     = cw_r;
        alu_b     = DW'(1);
        cw_nxt    = alu_res;
        state_nxt = ST_ADDACK;
      end
      ST_ADDACK: begin
        alu_op    = ALU_ADD;
        alu_a     = DW'(cnt_r);
        alu_b     = DW'(acked_r);
        acc_nxt   = alu_res;
        state_nxt = ST_DIVCHK;
      end
      // skip the divide when the count stays below target
      ST_DIVCHK: begin
        alu_a = acc_r;
        alu_b = opb_r;
        if (alu_lt) begin
          cnt_nxt   = sat_cnt(acc_r[DIV_BITS-1:0]);
          state_nxt = ST_CLAMP;
        end else begin
          rem_nxt   = '0;
          dq_nxt    = acc_r[DIV_BITS-1:0];
          step_nxt  = STEP_BITS'(DIV_BITS - 1);
          state_nxt = ST_DIV;
        end
      end
      // restoring divide, one quotient bit per cycle
      ST_DIV: begin
        alu_a   = part;
        alu_b   = opb_r;
        rem_nxt = alu_lt ? part : alu_res;
        dq_nxt  = {dq_r[DIV_BITS-2:0], !alu_lt};
        if (step_r == '0) begin
          state_nxt = ST_ADDQ;
        end else begin
          step_nxt = step_r - STEP_BITS'(1);
        end
      end
      ST_ADDQ: begin
        alu_op    = ALU_ADD;
        alu_a     = cw_r;
        alu_b     = DW'(dq_r);
        cw_nxt    = alu_res;
        cnt_nxt   = sat_cnt(rem_r[DIV_BITS-1:0]);
        state_nxt = ST_CLAMP;
      end
      ST_CLAMP: begin
        alu_a     = cw_r;
        alu_b     = DW'(clamp);
        cwnd_nxt  = alu_lt ? cw_r[CWND_BITS-1:0] : CWND_BITS'(clamp);
        state_nxt = ST_DONE;
      end
      // ssthresh = max(cwnd/2, 2)
      ST_REDUCE: begin
        alu_a     = DW'(half);
        alu_b     = DW'(MIN_SSTHRESH);
        ssth_nxt  = red_ssth;
        cwnd_nxt  = (kind_r == KIND_LOSS) ? red_ssth : CWND_BITS'(1);
        state_nxt = ST_DONE;
      end
      // hold until the output register is free
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_cwnd_nxt  = cwnd_r;
          out_ssth_nxt  = ssth_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cwnd_r      <= CWND_BITS'(1);
      ssth_r      <= '1;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cwnd_r      <= cwnd_nxt;
      ssth_r      <= ssth_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_cwnd_r <= out_cwnd_nxt;
    out_ssth_r <= out_ssth_nxt;
    kind_r     <= kind_nxt;
    acked_r    <= acked_nxt;
    srtt_r     <= srtt_nxt;
    acc_r      <= acc_nxt;
    opb_r      <= opb_nxt;
    cw_r       <= cw_nxt;
    rem_r      <= rem_nxt;
    dq_r       <= dq_nxt;
    step_r     <= step_nxt;
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r != ST_IDLE))
    else $error("sequencer idle right after a request");

  a_ssth_floor: assert property (@(posedge clk) disable iff (!rst_n)
    ssth_r >= CWND_BITS'(MIN_SSTHRESH))
    else $error("ssthresh below floor");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < opb_r))
    else $error("divide remainder not below target");

  a_ack_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && $past(state_r) == ST_CLAMP) |-> (DW'(cwnd_r) <= DW'(clamp)))
    else $error("window above clamp after ack");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result raised outside done state");

endmodule
